// ----- rtl/script_token_lexer_defines.svh -----
// ----------------------------------------------------------------------------
// Script token lexer assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_DEFINES_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante
`define STL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Check that cons holds in the cycle after ante
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define STL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// Script token lexer package
// Token record types, character codes, keyword matcher and operator decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    // Fixed field widths
    localparam int CH_W    = 8;
    localparam int CODE_W  = 8;
    localparam int START_W = 16;
    localparam int LEN_W   = 8;
    localparam int KW_W    = 4;

    // Parameter defaults
    localparam int POS_BITS_DEF    = 16;
    localparam int LEN_MAX_DEF     = 255;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Token kinds
    typedef enum logic [2:0] {
        K_OP   = 3'd0,
        K_KW   = 3'd1,
        K_ID   = 3'd2,
        K_INT  = 3'd3,
        K_REAL = 3'd4,
        K_STR  = 3'd5,
        K_SYM  = 3'd6,
        K_END  = 3'd7
    } t_kind;

    // Scanner modes
    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_OPER  = 3'd1,
        M_IDENT = 3'd2,
        M_INT   = 3'd3,
        M_REAL  = 3'd4,
        M_STR   = 3'd5
    } t_mode;

    // Operator codes
    localparam logic [CODE_W-1:0] OP_ASSIGN = 8'd0;
    localparam logic [CODE_W-1:0] OP_EQ     = 8'd1;
    localparam logic [CODE_W-1:0] OP_SET    = 8'd2;
    localparam logic [CODE_W-1:0] OP_PLUS   = 8'd3;
    localparam logic [CODE_W-1:0] OP_ARROW  = 8'd4;
    localparam logic [CODE_W-1:0] OP_MINUS  = 8'd5;
    localparam logic [CODE_W-1:0] OP_MUL    = 8'd6;
    localparam logic [CODE_W-1:0] OP_DIV    = 8'd7;
    localparam logic [CODE_W-1:0] OP_NE     = 8'd8;
    localparam logic [CODE_W-1:0] OP_NOT    = 8'd9;
    localparam logic [CODE_W-1:0] OP_GE     = 8'd10;
    localparam logic [CODE_W-1:0] OP_GT     = 8'd11;
    localparam logic [CODE_W-1:0] OP_LT     = 8'd12;
    localparam logic [CODE_W-1:0] OP_LARROW = 8'd13;
    localparam logic [CODE_W-1:0] OP_LE     = 8'd14;
    localparam logic [CODE_W-1:0] OP_OR     = 8'd15;
    localparam logic [CODE_W-1:0] OP_AND    = 8'd16;

    // Keyword codes
    localparam logic [CODE_W-1:0] KWC_TRUE  = 8'd0;
    localparam logic [CODE_W-1:0] KWC_FALSE = 8'd1;
    localparam logic [CODE_W-1:0] KWC_NIL   = 8'd2;
    localparam logic [CODE_W-1:0] CODE_NONE = 8'd0;

    // Keyword matcher states: dead, then one run per keyword
    localparam logic [KW_W-1:0] KW_DEAD       = 4'd0;
    localparam logic [KW_W-1:0] KW_TRUE_BASE  = 4'd1;
    localparam logic [KW_W-1:0] KW_TRUE_DONE  = 4'd4;
    localparam logic [KW_W-1:0] KW_FALSE_BASE = 4'd5;
    localparam logic [KW_W-1:0] KW_FALSE_DONE = 4'd9;
    localparam logic [KW_W-1:0] KW_NIL_BASE   = 4'd10;
    localparam logic [KW_W-1:0] KW_NIL_DONE   = 4'd12;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CH_W-1:0] CH_PIPE  = 8'h7C;
    localparam logic [CH_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

    // One token record
    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    len;
        logic                space;
    } t_rec;

    // One queue entry: the records caused by one byte
    typedef struct packed {
        t_rec rec_a;
        t_rec rec_b;
        logic has_b;
    } t_entry;

    // Resolved pending operator
    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] code;
        logic              two;
    } t_op_res;

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_op_start(input logic [CH_W-1:0] c);
        return c == CH_COLON || c == CH_EQ || c == CH_MINUS || c == CH_BANG ||
               c == CH_GT || c == CH_LT || c == CH_PIPE || c == CH_AMP;
    endfunction

    // First letter of a possible keyword
    function automatic logic [KW_W-1:0] kw_first(input logic [CH_W-1:0] c);
        logic [KW_W-1:0] s;
        s = KW_DEAD;
        if (c == 8'h74) s = KW_TRUE_BASE;
        else if (c == 8'h66) s = KW_FALSE_BASE;
        else if (c == 8'h6E) s = KW_NIL_BASE;
        return s;
    endfunction

    // Advance the keyword matcher by one letter
    function automatic logic [KW_W-1:0] kw_next(input logic [KW_W-1:0] s,
                                                 input logic [CH_W-1:0] c);
        logic [CH_W-1:0] want;
        logic            live;
        want = CH_NUL;
        live = 1'b1;
        unique case (s)
            KW_TRUE_BASE:         want = 8'h72; // r
            KW_TRUE_BASE + 4'd1:  want = 8'h75; // u
            KW_TRUE_BASE + 4'd2:  want = 8'h65; // e
            KW_FALSE_BASE:        want = 8'h61; // a
            KW_FALSE_BASE + 4'd1: want = 8'h6C; // l
            KW_FALSE_BASE + 4'd2: want = 8'h73; // s
            KW_FALSE_BASE + 4'd3: want = 8'h65; // e
            KW_NIL_BASE:          want = 8'h69; // i
            KW_NIL_BASE + 4'd1:   want = 8'h6C; // l
            default:              live = 1'b0;
        endcase
        return (live && c == want) ? s + 4'd1 : KW_DEAD;
    endfunction

    // Decide a pending operator byte against the byte after it
    function automatic t_op_res op_resolve(input logic [CH_W-1:0] c,
                                           input logic [CH_W-1:0] b);
        t_op_res r;
        r.kind = K_OP;
        r.code = c;
        r.two  = 1'b0;
        unique case (c)
            CH_COLON: begin
                if (b == CH_EQ) begin
                    r.code = OP_ASSIGN;
                    r.two  = 1'b1;
                end else begin
                    r.kind = K_SYM;
                end
            end
            CH_EQ: begin
                r.two  = (b == CH_EQ);
                r.code = r.two ? OP_EQ : OP_SET;
            end
            CH_MINUS: begin
                r.two  = (b == CH_GT);
                r.code = r.two ? OP_ARROW : OP_MINUS;
            end
            CH_BANG: begin
                r.two  = (b == CH_EQ);
                r.code = r.two ? OP_NE : OP_NOT;
            end
            CH_GT: begin
                r.two  = (b == CH_EQ);
                r.code = r.two ? OP_GE : OP_GT;
            end
            CH_LT: begin
                if (b == CH_EQ) begin
                    r.code = OP_LE;
                    r.two  = 1'b1;
                end else if (b == CH_MINUS) begin
                    r.code = OP_LARROW;
                    r.two  = 1'b1;
                end else begin
                    r.code = OP_LT;
                end
            end
            CH_PIPE: begin
                if (b == CH_PIPE) begin
                    r.code = OP_OR;
                    r.two  = 1'b1;
                end else begin
                    r.kind = K_SYM;
                end
            end
            CH_AMP: begin
                if (b == CH_AMP) begin
                    r.code = OP_AND;
                    r.two  = 1'b1;
                end else begin
                    r.kind = K_SYM;
                end
            end
            default: r.kind = K_SYM;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/stl_queue.sv -----
// ----------------------------------------------------------------------------
// Script token lexer record queue
// Short FIFO of per-byte record bundles between scanner and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_queue
    import stl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_wdata,
    input  wire logic   i_pop,
    output t_entry      o_rdata,
    output logic        o_full,
    output logic        o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the bundle
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_wdata;
    end

endmodule

`default_nettype wire

// ----- rtl/stl_front.sv -----
// ----------------------------------------------------------------------------
// Script token lexer scanner
// Takes one byte per cycle while the queue is not full, tracks the scan mode and builds token records.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_front
    import stl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int LEN_MAX  = LEN_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [CH_W-1:0]   i_ch,
    output logic                   o_ready,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_entry                 o_entry,
    output logic                   o_done
);

    localparam int              LEN_CAP_I = (LEN_MAX < 255) ? LEN_MAX : 255;
    localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(LEN_CAP_I);

    t_mode                 r_mode, n_mode;
    logic [CH_W-1:0]       r_pend, n_pend;
    logic [POS_BITS-1:0]   r_pos;
    logic [START_W-1:0]    r_start, n_start;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_saw, n_saw;
    logic [KW_W-1:0]       r_kw, n_kw;
    logic                  r_done, n_done;

    logic                  accept;
    logic                  used;
    logic                  e0, e1;
    t_rec                  rec0, rec1;
    t_op_res               opr;
    logic [START_W-1:0]    pos_s, pos_nx;
    logic [LEN_W-1:0]      len_up;

    assign o_ready = r_done || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_done  = r_done;
    assign pos_s   = START_W'(r_pos);
    assign pos_nx  = START_W'(POS_BITS'(r_pos + 1'b1));
    assign len_up  = (r_len < LEN_CAP) ? r_len + 1'b1 : r_len;
    assign opr     = op_resolve(r_pend, i_ch);

    // Finish the token in progress, then handle the byte on its own
    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_start = r_start;
        n_len   = r_len;
        n_kw    = r_kw;
        n_done  = r_done;
        used    = 1'b0;
        e0      = 1'b0;
        e1      = 1'b0;
        rec0    = '0;
        rec1    = '0;
        rec0.start = r_start;
        rec0.len   = r_len;
        rec0.space = r_saw;

        unique case (r_mode)
            M_OPER: begin
                e0        = 1'b1;
                rec0.kind = opr.kind;
                rec0.code = opr.code;
                rec0.len  = opr.two ? 8'd2 : 8'd1;
                n_mode    = M_IDLE;
                used      = opr.two;
            end
            M_IDENT: begin
                if (is_alpha(i_ch) || is_digit(i_ch)) begin
                    n_len = len_up;
                    n_kw  = kw_next(r_kw, i_ch);
                    used  = 1'b1;
                end else begin
                    e0        = 1'b1;
                    rec0.kind = K_KW;
                    if (r_kw == KW_TRUE_DONE) rec0.code = KWC_TRUE;
                    else if (r_kw == KW_FALSE_DONE) rec0.code = KWC_FALSE;
                    else if (r_kw == KW_NIL_DONE) rec0.code = KWC_NIL;
                    else rec0.kind = K_ID;
                    n_mode = M_IDLE;
                end
            end
            M_INT: begin
                if (is_digit(i_ch)) begin
                    n_len = len_up;
                    used  = 1'b1;
                end else if (i_ch == CH_DOT) begin
                    n_len  = len_up;
                    n_mode = M_REAL;
                    used   = 1'b1;
                end else begin
                    e0        = 1'b1;
                    rec0.kind = K_INT;
                    n_mode    = M_IDLE;
                end
            end
            M_REAL: begin
                if (is_digit(i_ch)) begin
                    n_len = len_up;
                    used  = 1'b1;
                end else begin
                    e0        = 1'b1;
                    rec0.kind = K_REAL;
                    n_mode    = M_IDLE;
                end
            end
            M_STR: begin
                if (i_ch == CH_NUL) begin
                    e0        = 1'b1;
                    rec0.kind = K_STR;
                    n_mode    = M_IDLE;
                end else if (i_ch == CH_QUOTE) begin
                    e0        = 1'b1;
                    rec0.kind = K_STR;
                    n_mode    = M_IDLE;
                    used      = 1'b1;
                end else begin
                    n_len = len_up;
                    used  = 1'b1;
                end
            end
            default: n_mode = M_IDLE;
        endcase

        // Byte not consumed by the token in progress
        rec1.kind  = K_SYM;
        rec1.code  = i_ch;
        rec1.start = pos_s;
        rec1.len   = 8'd1;
        rec1.space = e0 ? 1'b0 : r_saw;
        if (!used) begin
            if (i_ch == CH_NUL) begin
                e1        = 1'b1;
                rec1.kind = K_END;
                rec1.code = CODE_NONE;
                rec1.len  = '0;
                n_done    = 1'b1;
            end else if (is_space(i_ch)) begin
                e1 = 1'b0;
            end else if (is_alpha(i_ch)) begin
                n_mode  = M_IDENT;
                n_start = pos_s;
                n_len   = 8'd1;
                n_kw    = kw_first(i_ch);
            end else if (is_digit(i_ch)) begin
                n_mode  = M_INT;
                n_start = pos_s;
                n_len   = 8'd1;
            end else if (i_ch == CH_QUOTE) begin
                n_mode  = M_STR;
                n_start = pos_nx;
                n_len   = '0;
            end else if (is_op_start(i_ch)) begin
                n_mode  = M_OPER;
                n_pend  = i_ch;
                n_start = pos_s;
                n_len   = 8'd1;
            end else if (i_ch == CH_PLUS) begin
                e1        = 1'b1;
                rec1.kind = K_OP;
                rec1.code = OP_PLUS;
            end else if (i_ch == CH_STAR) begin
                e1        = 1'b1;
                rec1.kind = K_OP;
                rec1.code = OP_MUL;
            end else if (i_ch == CH_SLASH) begin
                e1        = 1'b1;
                rec1.kind = K_OP;
                rec1.code = OP_DIV;
            end else begin
                e1 = 1'b1;
            end
        end

        // Set on skipped whitespace, else clear on any record
        if (!used && is_space(i_ch)) n_saw = 1'b1;
        else if (e0 || e1) n_saw = 1'b0;
        else n_saw = r_saw;
    end

    // Pack the bundle: lone second record moves into the first slot
    always_comb begin
        o_entry.rec_a = e0 ? rec0 : rec1;
        o_entry.rec_b = rec1;
        o_entry.has_b = e0 && e1;
        o_push        = accept && !r_done && (e0 || e1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pend  <= '0;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_saw   <= 1'b0;
            r_kw    <= KW_DEAD;
            r_done  <= 1'b0;
        end else if (accept && !r_done) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_pos   <= r_pos + 1'b1;
            r_start <= n_start;
            r_len   <= n_len;
            r_saw   <= n_saw;
            r_kw    <= n_kw;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stl_back.sv -----
// ----------------------------------------------------------------------------
// Script token lexer output stage
// Pops record bundles and sends one record per transfer through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_back
    import stl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_rec        o_rec,
    output logic        o_last
);

    logic   r_valid, n_valid;
    logic   r_sel, n_sel;
    t_rec   r_rec, n_rec;
    logic   r_last, n_last;
    logic   load;

    assign load    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_last  = r_last;

    // Load the next record whenever the output register frees up
    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_rec   = r_rec;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (r_sel) begin
                    n_rec  = i_head.rec_b;
                    n_last = 1'b1;
                    n_sel  = 1'b0;
                    o_pop  = 1'b1;
                end else begin
                    n_rec  = i_head.rec_a;
                    n_last = !i_head.has_b;
                    n_sel  = i_head.has_b;
                    o_pop  = !i_head.has_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_rec  <= n_rec;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

// ----- rtl/script_token_lexer.sv -----
// Path: a record is queued by the scanner, then loaded into the output register.
// Throughput: one byte per cycle in while the queue has room; one record per cycle
// out while the master side is ready, so the record queue absorbs two-record bytes.
// Reset: synchronous, active low; clears scan state, position, queue and output stage.
// Bytes after the end-of-input byte are taken and dropped until reset.
`default_nettype none

`include "script_token_lexer_defines.svh"

// ----------------------------------------------------------------------------
// Script token lexer
// Streaming tokenizer: scanner, record queue and output register.
// ----------------------------------------------------------------------------
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int LEN_MAX     = LEN_MAX_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] ch
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [39:0]        m_axis_tdata,   // [7:0] token_code, [23:8] start_pos,
                                               // [31:24] token_len, [32] space_before
    output logic [2:0]         m_axis_tuser,   // [2:0] token_kind
    output logic               m_axis_tlast
);

    logic   q_push, q_pop, q_full, q_empty;
    logic   f_done;
    t_entry q_wdata, q_rdata;
    t_rec   out_rec;

    // Scanner
    stl_front #(
        .POS_BITS (POS_BITS),
        .LEN_MAX  (LEN_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ch    (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_wdata),
        .o_done  (f_done)
    );

    // Record queue
    stl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Output stage
    stl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_rdata),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (out_rec),
        .o_last  (m_axis_tlast)
    );

    // Pack the record onto the master side
    assign m_axis_tdata = {7'b0, out_rec.space, out_rec.len, out_rec.start, out_rec.code};
    assign m_axis_tuser = out_rec.kind;

    // No record is queued once the end of input has been seen
    `STL_ASSERT_SAME(a_done_no_push, i_clk, i_rst_n, f_done, !q_push)
    // A full queue always has a head to drain
    `STL_ASSERT_SAME(a_full_not_empty, i_clk, i_rst_n, q_full, !q_empty)
    // The second record of a byte follows its first without a gap
    `STL_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

`default_nettype wire
